// ===== rtl/temp_humidity_compensation_core_assert.svh =====
// assertion macros for the temperature and humidity compensation core
// expects clk and rst_n in the scope of use
`ifndef TEMP_HUMIDITY_COMPENSATION_CORE_ASSERT_SVH
`define TEMP_HUMIDITY_COMPENSATION_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define THC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define THC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define THC_ASSERT_IMP(lbl, ante, cons, msg)

`define THC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/thc_pkg.sv =====
// shared types and constants for the compensation core
// no dependencies
`timescale 1ns / 1ps

package thc_pkg;

  localparam logic [2:0] REG_T1     = 3'd0;
  localparam logic [2:0] REG_T2     = 3'd1;
  localparam logic [2:0] REG_T3     = 3'd2;
  localparam logic [2:0] REG_H1_H3  = 3'd3;
  localparam logic [2:0] REG_H2     = 3'd4;
  localparam logic [2:0] REG_H4_H5  = 3'd5;
  localparam logic [2:0] REG_H6     = 3'd6;
  localparam logic [2:0] REG_HUM_EN = 3'd7;

  localparam logic signed [31:0] HUM_OFFSET  = 32'sd76800;
  localparam logic signed [31:0] HUM_CEILING = 32'sd419430400;
  localparam logic signed [31:0] HUM_ROUND_A = 32'sd16384;
  localparam logic signed [31:0] HUM_BIAS_B  = 32'sd32768;
  localparam logic signed [31:0] HUM_BIAS_C  = 32'sd2097152;
  localparam logic signed [31:0] HUM_ROUND_D = 32'sd8192;
  localparam logic signed [31:0] TEMP_ROUND  = 32'sd128;
  localparam logic [15:0]        DIV10_MUL   = 16'd52429;
  localparam int                 DIV10_SHIFT = 19;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [7:0]  h1;
    logic [7:0]  h3;
    logic [15:0] h2;
    logic [11:0] h4;
    logic [11:0] h5;
    logic [7:0]  h6;
    logic        hum_en;
  } thc_cfg_t;

  typedef struct packed {
    logic [31:0] fine;
    logic [31:0] x;
    logic [15:0] hraw;
  } thc_tmp_t;

  typedef struct packed {
    logic [19:0] tc;
    logic [23:0] fine;
    logic [16:0] hv;
  } thc_hum_t;

endpackage

// ===== rtl/thc_temp.sv =====
// temperature polynomial, three register stages
// depends on thc_pkg
`timescale 1ns / 1ps

module thc_temp import thc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  thc_cfg_t    cfg,
  input  logic        i_valid,
  output logic        i_ready,
  input  logic [19:0] i_traw,
  input  logic [15:0] i_hraw,
  output logic        o_valid,
  input  logic        o_ready,
  output thc_tmp_t    o_data
);

  logic [2:0] vld_r;
  logic [2:0] rdy;

  logic signed [31:0] t2x, t3x, a1, d;
  logic signed [31:0] p1_nxt, p2_nxt, p3_nxt, c1_nxt, fine_nxt;
  logic signed [31:0] p1_r, p2_r, p3_r, c1_r, fine_r, x_r;
  logic [15:0] hraw1_r, hraw2_r, hraw3_r;

  always_comb begin
    rdy[2] = !vld_r[2] || o_ready;
    for (int k = 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign i_ready = rdy[0];
  assign o_valid = vld_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= i_valid;
      if (rdy[1]) vld_r[1] <= vld_r[0];
      if (rdy[2]) vld_r[2] <= vld_r[1];
    end
  end

  assign t2x = $signed({{16{cfg.t2[15]}}, cfg.t2});
  assign t3x = $signed({{16{cfg.t3[15]}}, cfg.t3});
  assign a1  = $signed({15'b0, i_traw[19:3]}) - $signed({15'b0, cfg.t1, 1'b0});
  assign d   = $signed({16'b0, i_traw[19:4]}) - $signed({16'b0, cfg.t1});

  assign p1_nxt   = a1 * t2x;
  assign p2_nxt   = d * d;
  assign c1_nxt   = p1_r >>> 11;
  assign p3_nxt   = (p2_r >>> 12) * t3x;
  assign fine_nxt = c1_r + (p3_r >>> 14);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p1_r    <= p1_nxt;
      p2_r    <= p2_nxt;
      hraw1_r <= i_hraw;
    end
    if (rdy[1]) begin
      c1_r    <= c1_nxt;
      p3_r    <= p3_nxt;
      hraw2_r <= hraw1_r;
    end
    if (rdy[2]) begin
      fine_r  <= fine_nxt;
      x_r     <= fine_nxt - HUM_OFFSET;
      hraw3_r <= hraw2_r;
    end
  end

  assign o_data.fine = fine_r;
  assign o_data.x    = x_r;
  assign o_data.hraw = hraw3_r;

endmodule

// ===== rtl/thc_hum.sv =====
// humidity polynomial and clamp, seven register stages
// depends on thc_pkg
`timescale 1ns / 1ps

module thc_hum import thc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  thc_cfg_t cfg,
  input  logic     i_valid,
  output logic     i_ready,
  input  thc_tmp_t i_data,
  output logic     o_valid,
  input  logic     o_ready,
  output thc_hum_t o_data
);

  localparam int NS = 7;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] rdy;

  // coefficients
  logic signed [31:0] h1z, h2x, h3z, h4t, h5z, h6x;

  // stage payloads
  logic signed [31:0] fine_in, x_in;
  logic signed [31:0] tcw_nxt, m1_nxt, m2_nxt, h5x_nxt;
  logic signed [31:0] m1_r, m2_r, h5x_r;
  logic signed [31:0] a_nxt, b0_nxt, a5_r, b0_r;
  logic signed [31:0] b2_nxt, a6_r, b2_r;
  logic signed [31:0] r_nxt, r7_r;
  logic signed [31:0] qs, qq_nxt, r8_r, qq_r;
  logic signed [31:0] ht_nxt, r9_r, ht_r;
  logic signed [31:0] r2, rc;
  logic [16:0]        hv_nxt, hv_r;
  logic [15:0]        hraw4_r;
  logic [19:0]        tc_r [NS];
  logic [23:0]        fine_r [NS];

  always_comb begin
    rdy[NS-1] = !vld_r[NS-1] || o_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign i_ready = rdy[0];
  assign o_valid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= i_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign h1z = $signed({24'b0, cfg.h1});
  assign h3z = $signed({24'b0, cfg.h3});
  assign h2x = $signed({{16{cfg.h2[15]}}, cfg.h2});
  assign h4t = $signed({cfg.h4, 20'b0});
  assign h5z = $signed({20'b0, cfg.h5});
  assign h6x = $signed({{24{cfg.h6[7]}}, cfg.h6});

  assign fine_in = $signed(i_data.fine);
  assign x_in    = $signed(i_data.x);

  // first stage: temperature rounding and the three products of x
  assign tcw_nxt = (fine_in + (fine_in <<< 2) + TEMP_ROUND) >>> 8;
  assign m1_nxt  = x_in * h6x;
  assign m2_nxt  = x_in * h3z;
  assign h5x_nxt = h5z * x_in;

  assign a_nxt  = ($signed({2'b0, hraw4_r, 14'b0}) - h4t - h5x_r + HUM_ROUND_A) >>> 15;
  assign b0_nxt = (m1_r >>> 10) * ((m2_r >>> 11) + HUM_BIAS_B);
  assign b2_nxt = ((b0_r >>> 10) + HUM_BIAS_C) * h2x + HUM_ROUND_D;
  assign r_nxt  = a6_r * (b2_r >>> 14);
  assign qs     = r7_r >>> 15;
  assign qq_nxt = qs * qs;
  assign ht_nxt = (qq_r >>> 7) * h1z;
  assign r2     = r9_r - (ht_r >>> 4);

  always_comb begin
    if (r2[31]) begin
      rc = '0;
    end else if (r2 > HUM_CEILING) begin
      rc = HUM_CEILING;
    end else begin
      rc = r2;
    end
    hv_nxt = cfg.hum_en ? rc[28:12] : '0;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      m1_r      <= m1_nxt;
      m2_r      <= m2_nxt;
      h5x_r     <= h5x_nxt;
      hraw4_r   <= i_data.hraw;
      tc_r[0]   <= tcw_nxt[19:0];
      fine_r[0] <= i_data.fine[23:0];
    end
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) begin
        tc_r[k]   <= tc_r[k-1];
        fine_r[k] <= fine_r[k-1];
      end
    end
    if (rdy[1]) begin
      a5_r <= a_nxt;
      b0_r <= b0_nxt;
    end
    if (rdy[2]) begin
      a6_r <= a5_r;
      b2_r <= b2_nxt;
    end
    if (rdy[3]) begin
      r7_r <= r_nxt;
    end
    if (rdy[4]) begin
      r8_r <= r7_r;
      qq_r <= qq_nxt;
    end
    if (rdy[5]) begin
      r9_r <= r8_r;
      ht_r <= ht_nxt;
    end
    if (rdy[6]) begin
      hv_r <= hv_nxt;
    end
  end

  assign o_data.tc   = tc_r[NS-1];
  assign o_data.fine = fine_r[NS-1];
  assign o_data.hv   = hv_r;

endmodule

// ===== rtl/thc_div.sv =====
// divide by ten through a reciprocal product, output register stage
// depends on thc_pkg
`timescale 1ns / 1ps

module thc_div import thc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        i_valid,
  output logic        i_ready,
  input  thc_hum_t    i_data,
  output logic        o_valid,
  input  logic        o_ready,
  output logic [19:0] o_tc,
  output logic [23:0] o_fine,
  output logic [13:0] o_hum
);

  logic        vld_r;
  logic [32:0] prod;
  logic [13:0] hum_nxt, hum_r;
  logic [19:0] tc_r;
  logic [23:0] fine_r;

  assign i_ready = !vld_r || o_ready;
  assign o_valid = vld_r;

  assign prod    = {16'b0, i_data.hv} * {17'b0, DIV10_MUL};
  assign hum_nxt = prod[DIV10_SHIFT +: 14];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (i_ready) begin
      vld_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (i_ready) begin
      hum_r  <= hum_nxt;
      tc_r   <= i_data.tc;
      fine_r <= i_data.fine;
    end
  end

  assign o_tc   = tc_r;
  assign o_fine = fine_r;
  assign o_hum  = hum_r;

endmodule

// ===== rtl/temp_humidity_compensation_core.sv =====
// an accepted input word passes the temperature, humidity and divide register stages to out_tvalid
// throughput: one word per cycle, the pipeline stalls only when out_tready is held low
// the stall chain of eleven stage valid bits sets in_tready, a bubble is always filled
// reset: synchronous, active low; clears all valid bits, calibration to zero,
// humidity channel enabled
`timescale 1ns / 1ps
`include "temp_humidity_compensation_core_assert.svh"

module temp_humidity_compensation_core import thc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // raw_temperature[19:0], raw_humidity[35:20], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // temperature_centi[19:0], fine_temperature[43:20],
                                  // humidity_value[57:44], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  thc_cfg_t cfg_r;

  logic     tmp_valid, tmp_ready, hum_valid, hum_ready;
  thc_tmp_t tmp_data;
  thc_hum_t hum_data;

  logic [19:0] tc;
  logic [23:0] fine;
  logic [13:0] hum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{hum_en: 1'b1, default: '0};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_T1:     cfg_r.t1 <= cfg_data[15:0];
        REG_T2:     cfg_r.t2 <= cfg_data[15:0];
        REG_T3:     cfg_r.t3 <= cfg_data[15:0];
        REG_H1_H3:  {cfg_r.h3, cfg_r.h1} <= cfg_data[15:0];
        REG_H2:     cfg_r.h2 <= cfg_data[15:0];
        REG_H4_H5:  {cfg_r.h5, cfg_r.h4} <= cfg_data[23:0];
        REG_H6:     cfg_r.h6 <= cfg_data[7:0];
        REG_HUM_EN: cfg_r.hum_en <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  thc_temp u_temp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .i_valid (in_tvalid),
    .i_ready (in_tready),
    .i_traw  (in_tdata[19:0]),
    .i_hraw  (in_tdata[35:20]),
    .o_valid (tmp_valid),
    .o_ready (tmp_ready),
    .o_data  (tmp_data)
  );

  thc_hum u_hum (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .i_valid (tmp_valid),
    .i_ready (tmp_ready),
    .i_data  (tmp_data),
    .o_valid (hum_valid),
    .o_ready (hum_ready),
    .o_data  (hum_data)
  );

  thc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (hum_valid),
    .i_ready (hum_ready),
    .i_data  (hum_data),
    .o_valid (out_tvalid),
    .o_ready (out_tready),
    .o_tc    (tc),
    .o_fine  (fine),
    .o_hum   (hum)
  );

  assign out_tdata = {6'b0, hum, fine, tc};

  `THC_ASSERT_IMP(a_hum_range, out_tvalid, out_tdata[57:44] <= 14'd10240, "humidity out of range")
  `THC_ASSERT_IMP(a_stall_src, !in_tready, out_tvalid && !out_tready, "stall without full output")
  `THC_ASSERT_NXT(a_drain, out_tvalid && out_tready && !hum_valid, !out_tvalid, "word repeated")

endmodule
